// ----- sv/f2h_pkg.sv -----
package f2h_pkg;

  localparam logic MODE_S2H = 1'b0;
  localparam logic MODE_H2S = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] bits;
  } f2h_word_t;

  function automatic logic [15:0] s2h(input logic [31:0] x);
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  he;
    logic [10:0] hm;
    logic [54:0] t;
    logic        up;
    logic [15:0] r;
    sgn = x[31];
    e = x[30:23];
    m = x[22:0];
    he = '0;
    hm = '0;
    t = '0;
    up = 1'b0;
    if (e == 8'hff) begin
      r = (m == '0) ? {sgn, 15'h7c00} : 16'h7fff;
    end else if (e >= 8'h8f) begin
      r = {sgn, 5'd30, 10'h3ff};
    end else if (e <= 8'h70) begin
      if (e >= 8'h67) begin
        t = {31'd0, 1'b1, m} << (e - 8'h67);
        hm = {1'b0, t[32:23]};
        up = t[22] && ((t[21:0] != '0) || t[23]);
        hm = hm + {10'd0, up};
        if (hm[10]) he = 5'd1;
      end else if (e == 8'h66 && m != '0) begin
        hm = 11'd1;
      end
      r = {sgn, he, hm[9:0]};
    end else begin
      he = 5'(e - 8'h70);
      hm = {1'b0, m[22:13]};
      up = m[12] && ((m[11:0] != '0) || m[13]);
      hm = hm + {10'd0, up};
      if (hm[10]) begin
        he = he + 5'd1;
        hm = '0;
      end
      if (he == 5'd31) r = {sgn, 5'd30, 10'h3ff};
      else r = {sgn, he, hm[9:0]};
    end
    return r;
  endfunction

  function automatic logic [31:0] h2s(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [7:0]  se;
    logic [9:0]  mn;
    logic [31:0] r;
    sgn = h[15];
    e = h[14:10];
    m = h[9:0];
    se = 8'd113;
    mn = '0;
    if (e == 5'h1f) begin
      r = (m == '0) ? {sgn, 31'h7f800000} : 32'h7fffffff;
    end else if (e == '0) begin
      if (m == '0) begin
        r = {sgn, 31'd0};
      end else begin
        for (int i = 9; i >= 0; i--) begin
          if (m[i] && mn == '0) begin
            se = 8'd113 - 8'(10 - i);
            mn = 10'(m << (10 - i));
          end
        end
        r = {sgn, se, mn, 13'd0};
      end
    end else begin
      r = {sgn, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

endpackage

// ----- sv/fp32_fp16_converter.sv -----
// channel | signals                              | dir
// in      | in_valid_i in_stall_o mode_i operand_bits_i | sink
// out     | out_valid_o out_stall_i result_bits_o       | source
// Each word is registered at input, converted, and registered at output.
// One word per cycle sustained while the output is not stalled.
// Reset clears the valid flags only.
// Input stalls only when both stages are full and output is stalled.
module fp32_fp16_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_bits_o
);
  import f2h_pkg::*;

  f2h_word_t   in_q;
  logic        in_v_q;
  logic [31:0] res_d, res_q;
  logic        out_v_q;
  logic        adv_out, adv_in;

  f2h_core u_core (.word_i(in_q), .result_o(res_d));

  assign adv_out    = in_v_q && (!out_v_q || !out_stall_i);
  assign adv_in     = !in_v_q || adv_out;
  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_in) in_v_q <= in_valid_i;
      if (adv_out) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) in_q <= '{mode: mode_i, bits: operand_bits_i};
    if (adv_out) res_q <= res_d;
  end

  assign out_valid_o   = out_v_q;
  assign result_bits_o = res_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q && $stable(res_q))
    else $error("result lost under stall");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_v_q && out_v_q)
    else $error("stall without full pipe");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_out |=> out_v_q)
    else $error("result not shown");
endmodule

// ----- sv/f2h_core.sv -----
module f2h_core (
  input  f2h_pkg::f2h_word_t word_i,
  output logic [31:0]        result_o
);
  import f2h_pkg::*;

  always_comb begin
    case (word_i.mode)
      MODE_S2H: result_o = {16'd0, s2h(word_i.bits)};
      MODE_H2S: result_o = h2s(word_i.bits[15:0]);
      default:  result_o = '0;
    endcase
  end
endmodule
